### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/ffea_pkg.sv
// Package: types and constants of the first-fit extent allocator.
`default_nettype none
package ffea_pkg;
    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int PAGE_W        = 27;
    localparam int NPG_W         = 28;
    localparam int LEN_W         = 39;
    localparam int PAGE_SHIFT    = 12;
    localparam int Q_DEPTH       = 2;
    localparam int QP_W          = $clog2(Q_DEPTH);
    localparam int QC_W          = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {OP_INIT, OP_ALLOC, OP_FREE, OP_NONE} opcode_t;

    typedef enum logic [2:0] {
        ST_OK, ST_ZERO, ST_NOFIT, ST_FULL, ST_RANGE, ST_OVERLAP
    } status_t;

    typedef enum logic [1:0] {K_DONE, K_INIT, K_ALLOC, K_FREE} kind_t;

    typedef struct packed {
        kind_t              kind;
        status_t            st;
        logic [PAGE_W-1:0]  spage;
        logic [NPG_W-1:0]   amount;
        logic [NPG_W-1:0]   epage;
    } cmd_t;

    typedef struct packed {
        logic [PAGE_W-1:0]  start;
        logic [NPG_W-1:0]   len;
    } extent_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef enum logic [2:0] {
        B_IDLE, B_SCAN_RD, B_SCAN_CHK, B_SD_RD, B_SD_WR, B_SU_RD, B_SU_WR
    } bstate_t;
endpackage
`default_nettype wire

### rtl/first_fit_extent_allocator_core.sv
// Top level: config registers, front end, command queue, table sequencer.
//
//  channel   ports                                       handshake
//  request   opcode, start_page, length_bytes            start & !busy
//  result    alloc_page, status                          done (one cycle)
//  config    cfg_index, cfg_data                         cfg_valid & cfg_ready
//
//  An item passes through the front register and the command queue to the
//  sequencer, which handles init, rejected or unused items in its idle state
//  and otherwise scans table entries and shifts entries on removal or
//  insertion, all paced by the single read port of the extent table; results
//  are registered.
//  Reset empties the table and loads base 0, 4096 pages.
//  Results cannot be stalled; busy rises only when the queue and the front
//  register are both full.
`default_nettype none
module first_fit_extent_allocator_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    opcode,
    input  wire logic [ffea_pkg::PAGE_W-1:0]   start_page,
    input  wire logic [ffea_pkg::LEN_W-1:0]    length_bytes,
    output logic                               done,
    output logic [ffea_pkg::PAGE_W-1:0]        alloc_page,
    output logic [2:0]                         status,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [ffea_pkg::NPG_W-1:0]    cfg_data
);
    logic [ffea_pkg::PAGE_W-1:0]  base_reg;
    logic [ffea_pkg::NPG_W-1:0]   pages_reg;
    ffea_pkg::q_stat_t            q_stat;
    ffea_pkg::cmd_t               push_cmd, head;
    logic                         push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            pages_reg <= ffea_pkg::NPG_W'(4096);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index)
            begin
                pages_reg <= cfg_data;
            end
            else
            begin
                base_reg <= cfg_data[ffea_pkg::PAGE_W-1:0];
            end
        end
    end

    ffea_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .start_page   (start_page),
        .length_bytes (length_bytes),
        .base_page    (base_reg),
        .heap_pages   (pages_reg),
        .q_stat       (q_stat),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    ffea_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_stat   (q_stat),
        .head     (head)
    );

    ffea_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .alloc_page (alloc_page),
        .status     (status)
    );
endmodule
`default_nettype wire

### rtl/ffea_front.sv
// Front end: takes items, checks ranges and lengths, pushes commands.
`default_nettype none
module ffea_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    opcode,
    input  wire logic [ffea_pkg::PAGE_W-1:0]   start_page,
    input  wire logic [ffea_pkg::LEN_W-1:0]    length_bytes,
    input  wire logic [ffea_pkg::PAGE_W-1:0]   base_page,
    input  wire logic [ffea_pkg::NPG_W-1:0]    heap_pages,
    input  wire ffea_pkg::q_stat_t             q_stat,
    output logic                               push,
    output ffea_pkg::cmd_t                     push_cmd
);
    localparam logic [ffea_pkg::NPG_W:0] SPACE = (ffea_pkg::NPG_W + 1)'(1) << ffea_pkg::PAGE_W;

    logic                             f_valid_reg, f_valid_next;
    ffea_pkg::opcode_t                f_op_reg;
    logic [ffea_pkg::PAGE_W-1:0]      f_sp_reg;
    logic [ffea_pkg::LEN_W-1:0]       f_len_reg;
    logic                             accept;
    logic [ffea_pkg::NPG_W:0]         wend_raw;
    logic [ffea_pkg::NPG_W-1:0]       wend, base_x, pages, need, epage, init_len;

    assign busy   = f_valid_reg && q_stat.full;
    assign accept = start && !busy;
    assign push   = f_valid_reg && !q_stat.full;

    always_comb
    begin
        f_valid_next = accept ? 1'b1 : (push ? 1'b0 : f_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_op_reg  <= ffea_pkg::opcode_t'(opcode);
            f_sp_reg  <= start_page;
            f_len_reg <= length_bytes;
        end
    end

    always_comb
    begin
        base_x   = ffea_pkg::NPG_W'(base_page);
        wend_raw = (ffea_pkg::NPG_W + 1)'(base_page) + (ffea_pkg::NPG_W + 1)'(heap_pages);
        wend     = (wend_raw > SPACE) ? SPACE[ffea_pkg::NPG_W-1:0]
                                      : wend_raw[ffea_pkg::NPG_W-1:0];
        init_len = (wend > base_x) ? (wend - base_x) : '0;
        pages    = ffea_pkg::NPG_W'(f_len_reg[ffea_pkg::LEN_W-1:ffea_pkg::PAGE_SHIFT]);
        need     = pages + ffea_pkg::NPG_W'(|f_len_reg[ffea_pkg::PAGE_SHIFT-1:0]);
        epage    = ffea_pkg::NPG_W'(f_sp_reg) + pages;

        push_cmd        = '0;
        push_cmd.kind   = ffea_pkg::K_DONE;
        push_cmd.st     = ffea_pkg::ST_OK;
        push_cmd.spage  = f_sp_reg;
        push_cmd.epage  = epage;
        unique case (f_op_reg)
            ffea_pkg::OP_INIT:
            begin
                push_cmd.kind   = ffea_pkg::K_INIT;
                push_cmd.spage  = base_page;
                push_cmd.amount = init_len;
            end
            ffea_pkg::OP_ALLOC:
            begin
                push_cmd.amount = need;
                if (f_len_reg == '0)
                begin
                    push_cmd.st = ffea_pkg::ST_ZERO;
                end
                else
                begin
                    push_cmd.kind = ffea_pkg::K_ALLOC;
                end
            end
            ffea_pkg::OP_FREE:
            begin
                push_cmd.amount = pages;
                priority if (f_len_reg == '0)
                begin
                    push_cmd.st = ffea_pkg::ST_ZERO;
                end
                else if (f_len_reg[ffea_pkg::PAGE_SHIFT-1:0] != '0)
                begin
                    push_cmd.st = ffea_pkg::ST_RANGE;
                end
                else if (f_sp_reg < base_page || epage > wend)
                begin
                    push_cmd.st = ffea_pkg::ST_RANGE;
                end
                else
                begin
                    push_cmd.kind = ffea_pkg::K_FREE;
                end
            end
            default:
            begin
                push_cmd.kind = ffea_pkg::K_DONE;
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/ffea_queue.sv
// Command queue between front end and table sequencer.
`default_nettype none
module ffea_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ffea_pkg::cmd_t  push_cmd,
    input  wire logic            pop,
    output ffea_pkg::q_stat_t    q_stat,
    output ffea_pkg::cmd_t       head
);
    ffea_pkg::cmd_t              slot_reg [ffea_pkg::Q_DEPTH];
    logic [ffea_pkg::QP_W-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [ffea_pkg::QC_W-1:0]   cnt_reg, cnt_next;

    assign q_stat.valid = (cnt_reg != '0);
    assign q_stat.full  = (cnt_reg == ffea_pkg::QC_W'(ffea_pkg::Q_DEPTH));
    assign head         = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ffea_pkg::QP_W'((32'(wr_reg) + 1) % ffea_pkg::Q_DEPTH) : wr_reg;
        rd_next  = pop  ? ffea_pkg::QP_W'((32'(rd_reg) + 1) % ffea_pkg::Q_DEPTH) : rd_reg;
        cnt_next = cnt_reg + ffea_pkg::QC_W'(push) - ffea_pkg::QC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end
endmodule
`default_nettype wire

### rtl/ffea_back.sv
// Table sequencer: first-fit scan, insertion search, entry shifts, results.
`default_nettype none
module ffea_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ffea_pkg::q_stat_t            q_stat,
    input  wire ffea_pkg::cmd_t               head,
    output logic                              pop,
    output logic                              done,
    output logic [ffea_pkg::PAGE_W-1:0]       alloc_page,
    output logic [2:0]                        status
);
    localparam int P1 = ffea_pkg::NPG_W + 1;

    ffea_pkg::extent_t               mem [ffea_pkg::TABLE_ENTRIES];
    ffea_pkg::extent_t               rdata_reg, wdata, r;
    logic                            we;
    logic [ffea_pkg::IDX_W-1:0]      waddr, raddr;

    ffea_pkg::bstate_t               state_reg, state_next;
    ffea_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [ffea_pkg::CNT_W-1:0]      count_reg, count_next, i_reg, i_next;
    logic [ffea_pkg::CNT_W-1:0]      pos_reg, pos_next, j_reg, j_next, j1, jm1, posm1;
    ffea_pkg::extent_t               prev_reg, prev_next, nxt_reg, nxt_next;
    logic                            prev_ok_reg, prev_ok_next, nxt_ok_reg, nxt_ok_next;
    logic [ffea_pkg::PAGE_W-1:0]     page_reg, page_next;
    logic                            done_reg, done_next;
    logic [ffea_pkg::PAGE_W-1:0]     page_out_reg, page_out_next;
    ffea_pkg::status_t               st_out_reg, st_out_next;
    logic [P1-1:0]                   r_end, prev_end;
    logic                            mp, mn, ovl;

    assign done       = done_reg;
    assign alloc_page = page_out_reg;
    assign status     = st_out_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        r        = rdata_reg;
        j1       = j_reg + 1'b1;
        jm1      = j_reg - 1'b1;
        posm1    = pos_reg - 1'b1;
        r_end    = P1'(r.start) + P1'(r.len);
        prev_end = P1'(prev_reg.start) + P1'(prev_reg.len);
        ovl      = (P1'(cmd_reg.spage) < r_end) && (P1'(r.start) < P1'(cmd_reg.epage));
        mp       = prev_ok_reg && (prev_end == P1'(cmd_reg.spage));
        mn       = nxt_ok_reg && (ffea_pkg::NPG_W'(nxt_reg.start) == cmd_reg.epage);

        state_next    = state_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        prev_next     = prev_reg;
        prev_ok_next  = prev_ok_reg;
        nxt_next      = nxt_reg;
        nxt_ok_next   = nxt_ok_reg;
        page_next     = page_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        raddr         = '0;
        pop           = 1'b0;
        done_next     = 1'b0;
        page_out_next = '0;
        st_out_next   = ffea_pkg::ST_OK;

        unique case (state_reg)
            ffea_pkg::B_IDLE:
            begin
                if (q_stat.valid)
                begin
                    pop          = 1'b1;
                    cmd_next     = head;
                    i_next       = '0;
                    pos_next     = '0;
                    prev_ok_next = 1'b0;
                    nxt_ok_next  = 1'b0;
                    page_next    = '0;
                    unique case (head.kind)
                        ffea_pkg::K_DONE:
                        begin
                            done_next   = 1'b1;
                            st_out_next = head.st;
                        end
                        ffea_pkg::K_INIT:
                        begin
                            done_next = 1'b1;
                            if (head.amount != '0)
                            begin
                                we         = 1'b1;
                                wdata      = '{start: head.spage, len: head.amount};
                                count_next = ffea_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                count_next = '0;
                            end
                        end
                        default:
                        begin
                            state_next = ffea_pkg::B_SCAN_RD;
                        end
                    endcase
                end
            end
            ffea_pkg::B_SCAN_RD:
            begin
                if (i_reg != count_reg)
                begin
                    raddr      = i_reg[ffea_pkg::IDX_W-1:0];
                    state_next = ffea_pkg::B_SCAN_CHK;
                end
                else if (cmd_reg.kind == ffea_pkg::K_ALLOC)
                begin
                    done_next   = 1'b1;
                    st_out_next = ffea_pkg::ST_NOFIT;
                    state_next  = ffea_pkg::B_IDLE;
                end
                else
                begin
                    state_next = ffea_pkg::B_IDLE;
                    priority if (mp && mn)
                    begin
                        we         = 1'b1;
                        waddr      = posm1[ffea_pkg::IDX_W-1:0];
                        wdata      = '{start: prev_reg.start,
                                       len: prev_reg.len + cmd_reg.amount + nxt_reg.len};
                        j_next     = pos_reg;
                        state_next = ffea_pkg::B_SD_RD;
                    end
                    else if (mp)
                    begin
                        we        = 1'b1;
                        waddr     = posm1[ffea_pkg::IDX_W-1:0];
                        wdata     = '{start: prev_reg.start, len: prev_reg.len + cmd_reg.amount};
                        done_next = 1'b1;
                    end
                    else if (mn)
                    begin
                        we        = 1'b1;
                        waddr     = pos_reg[ffea_pkg::IDX_W-1:0];
                        wdata     = '{start: cmd_reg.spage, len: nxt_reg.len + cmd_reg.amount};
                        done_next = 1'b1;
                    end
                    else if (count_reg == ffea_pkg::CNT_W'(ffea_pkg::TABLE_ENTRIES))
                    begin
                        done_next   = 1'b1;
                        st_out_next = ffea_pkg::ST_FULL;
                    end
                    else
                    begin
                        j_next     = count_reg;
                        state_next = ffea_pkg::B_SU_RD;
                    end
                end
            end
            ffea_pkg::B_SCAN_CHK:
            begin
                i_next     = i_reg + 1'b1;
                state_next = ffea_pkg::B_SCAN_RD;
                if (cmd_reg.kind == ffea_pkg::K_ALLOC)
                begin
                    if (r.len >= cmd_reg.amount)
                    begin
                        page_next = r.start;
                        if (r.len == cmd_reg.amount)
                        begin
                            j_next     = i_reg;
                            state_next = ffea_pkg::B_SD_RD;
                        end
                        else
                        begin
                            we            = 1'b1;
                            waddr         = i_reg[ffea_pkg::IDX_W-1:0];
                            wdata         = '{start: r.start + cmd_reg.amount[ffea_pkg::PAGE_W-1:0],
                                              len: r.len - cmd_reg.amount};
                            done_next     = 1'b1;
                            page_out_next = r.start;
                            state_next    = ffea_pkg::B_IDLE;
                        end
                    end
                end
                else if (ovl)
                begin
                    done_next   = 1'b1;
                    st_out_next = ffea_pkg::ST_OVERLAP;
                    state_next  = ffea_pkg::B_IDLE;
                end
                else if (r.start < cmd_reg.spage)
                begin
                    prev_next    = r;
                    prev_ok_next = 1'b1;
                    pos_next     = pos_reg + 1'b1;
                end
                else if (!nxt_ok_reg)
                begin
                    nxt_next    = r;
                    nxt_ok_next = 1'b1;
                end
            end
            ffea_pkg::B_SD_RD:
            begin
                if (j1 >= count_reg)
                begin
                    count_next    = count_reg - 1'b1;
                    done_next     = 1'b1;
                    page_out_next = page_reg;
                    state_next    = ffea_pkg::B_IDLE;
                end
                else
                begin
                    raddr      = j1[ffea_pkg::IDX_W-1:0];
                    state_next = ffea_pkg::B_SD_WR;
                end
            end
            ffea_pkg::B_SD_WR:
            begin
                we         = 1'b1;
                waddr      = j_reg[ffea_pkg::IDX_W-1:0];
                wdata      = r;
                j_next     = j1;
                state_next = ffea_pkg::B_SD_RD;
            end
            ffea_pkg::B_SU_RD:
            begin
                if (j_reg == pos_reg)
                begin
                    we         = 1'b1;
                    waddr      = pos_reg[ffea_pkg::IDX_W-1:0];
                    wdata      = '{start: cmd_reg.spage, len: cmd_reg.amount};
                    count_next = count_reg + 1'b1;
                    done_next  = 1'b1;
                    state_next = ffea_pkg::B_IDLE;
                end
                else
                begin
                    raddr      = jm1[ffea_pkg::IDX_W-1:0];
                    state_next = ffea_pkg::B_SU_WR;
                end
            end
            ffea_pkg::B_SU_WR:
            begin
                we         = 1'b1;
                waddr      = j_reg[ffea_pkg::IDX_W-1:0];
                wdata      = r;
                j_next     = jm1;
                state_next = ffea_pkg::B_SU_RD;
            end
            default:
            begin
                state_next = ffea_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffea_pkg::B_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        i_reg        <= i_next;
        pos_reg      <= pos_next;
        j_reg        <= j_next;
        prev_reg     <= prev_next;
        prev_ok_reg  <= prev_ok_next;
        nxt_reg      <= nxt_next;
        nxt_ok_reg   <= nxt_ok_next;
        page_reg     <= page_next;
        page_out_reg <= page_out_next;
        st_out_reg   <= st_out_next;
    end
endmodule
`default_nettype wire

### rtl/ffea_checker.sv
// Port-level checker for the allocator core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ffea_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [ffea_pkg::PAGE_W-1:0]   alloc_page,
    input wire logic [2:0]                    status
);
    `ASSERT_IMPL(a_status_code, done, status <= 3'(ffea_pkg::ST_OVERLAP), "bad status code")
    `ASSERT_IMPL(a_page_zero, done && status != ffea_pkg::ST_OK, alloc_page == '0, "page set")
    `ASSERT_IMPL(a_busy_rise, $rose(busy), $past(start && !busy), "busy rose without an item")
endmodule

bind first_fit_extent_allocator_core ffea_checker u_ffea_checker (.*);
`default_nettype wire

### sim/tb.sv
// Testbench for first_fit_extent_allocator_core: directed and random requests.
`default_nettype none
module tb;
    localparam int    TABLE_ENTRIES = ffea_pkg::TABLE_ENTRIES;
    localparam int    PAGE_W     = ffea_pkg::PAGE_W;
    localparam int    NPG_W      = ffea_pkg::NPG_W;
    localparam int    LEN_W      = ffea_pkg::LEN_W;
    localparam int    PAGE_SHIFT = ffea_pkg::PAGE_SHIFT;
    localparam int    LATENCY  = 4 * TABLE_ENTRIES + 16;
    localparam int    WD_LIMIT = 4000;
    localparam longint unsigned PSPACE = 64'd1 << 27;
    localparam int    CFG_BASE  = 0;
    localparam int    CFG_PAGES = 1;

    typedef struct {
        logic [PAGE_W-1:0]  page;
        ffea_pkg::status_t  st;
    } grant_t;

    typedef struct {
        longint unsigned page;
        longint unsigned npg;
    } span_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        opcode;
    logic [PAGE_W-1:0] start_page;
    logic [LEN_W-1:0]  length_bytes;
    logic              done;
    logic [PAGE_W-1:0] alloc_page;
    logic [2:0]        status;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [NPG_W-1:0]  cfg_data;

    // predictor state
    longint unsigned ext_start [TABLE_ENTRIES];
    longint unsigned ext_len [TABLE_ENTRIES];
    int              ext_cnt;
    longint unsigned heap_base;
    longint unsigned heap_npg;

    grant_t expected_grants[$];
    span_t  held_spans[$];
    int     mismatches;
    int     idle_pct;
    int     stall_cnt;

    first_fit_extent_allocator_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .start_page(start_page), .length_bytes(length_bytes),
        .done(done), .alloc_page(alloc_page), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic longint unsigned window_top();
        longint unsigned e;
        e = heap_base + heap_npg;
        return (e > PSPACE) ? PSPACE : e;
    endfunction

    function automatic void drop_extent(int pos);
        for (int i = pos; i + 1 < ext_cnt; i++)
        begin
            ext_start[i] = ext_start[i + 1];
            ext_len[i]   = ext_len[i + 1];
        end
        ext_cnt--;
    endfunction

    function automatic ffea_pkg::status_t take_pages(longint unsigned nbytes,
                                                     output longint unsigned pg);
        longint unsigned need;
        pg = 0;
        if (nbytes == 0)
            return ffea_pkg::ST_ZERO;
        need = (nbytes + 4095) >> PAGE_SHIFT;
        for (int i = 0; i < ext_cnt; i++)
        begin
            if (ext_len[i] >= need)
            begin
                pg = ext_start[i];
                if (ext_len[i] == need)
                    drop_extent(i);
                else
                begin
                    ext_start[i] += need;
                    ext_len[i]   -= need;
                end
                return ffea_pkg::ST_OK;
            end
        end
        return ffea_pkg::ST_NOFIT;
    endfunction

    function automatic ffea_pkg::status_t return_pages(longint unsigned s,
                                                       longint unsigned nbytes);
        longint unsigned npg;
        longint unsigned e;
        int  pos;
        bit  mp;
        bit  mn;
        if (nbytes == 0)
            return ffea_pkg::ST_ZERO;
        if (nbytes[11:0] != 0)
            return ffea_pkg::ST_RANGE;
        npg = nbytes >> PAGE_SHIFT;
        e   = s + npg;
        if (s < heap_base || e > window_top())
            return ffea_pkg::ST_RANGE;
        for (int i = 0; i < ext_cnt; i++)
            if (s < ext_start[i] + ext_len[i] && ext_start[i] < e)
                return ffea_pkg::ST_OVERLAP;
        pos = 0;
        while (pos < ext_cnt && ext_start[pos] < s)
            pos++;
        mp = pos > 0 && ext_start[pos - 1] + ext_len[pos - 1] == s;
        mn = pos < ext_cnt && ext_start[pos] == e;
        if (mp && mn)
        begin
            ext_len[pos - 1] += npg + ext_len[pos];
            drop_extent(pos);
        end
        else if (mp)
            ext_len[pos - 1] += npg;
        else if (mn)
        begin
            ext_start[pos] = s;
            ext_len[pos]  += npg;
        end
        else
        begin
            if (ext_cnt >= TABLE_ENTRIES)
                return ffea_pkg::ST_FULL;
            for (int i = ext_cnt; i > pos; i--)
            begin
                ext_start[i] = ext_start[i - 1];
                ext_len[i]   = ext_len[i - 1];
            end
            ext_start[pos] = s;
            ext_len[pos]   = npg;
            ext_cnt++;
        end
        return ffea_pkg::ST_OK;
    endfunction

    function automatic grant_t predict_grant(ffea_pkg::opcode_t op, longint unsigned sp,
                                             longint unsigned nbytes);
        grant_t          g;
        longint unsigned pg;
        longint unsigned e;
        g.page = '0;
        g.st   = ffea_pkg::ST_OK;
        case (op)
            ffea_pkg::OP_INIT:
            begin
                e = window_top();
                ext_cnt = 0;
                if (e > heap_base)
                begin
                    ext_start[0] = heap_base;
                    ext_len[0]   = e - heap_base;
                    ext_cnt      = 1;
                end
                held_spans.delete();
            end
            ffea_pkg::OP_ALLOC:
            begin
                g.st = take_pages(nbytes, pg);
                if (g.st == ffea_pkg::ST_OK)
                begin
                    g.page = pg[PAGE_W-1:0];
                    held_spans.push_back('{pg, (nbytes + 4095) >> PAGE_SHIFT});
                end
            end
            ffea_pkg::OP_FREE:
                g.st = return_pages(sp, nbytes);
            default: ;
        endcase
        return g;
    endfunction

    // sender: fields go out at a rising edge, acceptance sampled mid-cycle
    task automatic send_item(ffea_pkg::opcode_t op, logic [PAGE_W-1:0] sp,
                             logic [LEN_W-1:0] nbytes);
        bit accepted;
        start        <= 1'b1;
        opcode       <= op;
        start_page   <= sp;
        length_bytes <= nbytes;
        do
        begin
            @(negedge clk);
            accepted = !busy;
            @(posedge clk);
        end
        while (!accepted);
        expected_grants.push_back(predict_grant(op, sp, nbytes));
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(int idx, longint unsigned val);
        bit accepted;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx[0];
        cfg_data  <= val[NPG_W-1:0];
        do
        begin
            @(negedge clk);
            accepted = cfg_ready;
            @(posedge clk);
        end
        while (!accepted);
        cfg_valid <= 1'b0;
        if (idx == CFG_BASE)
            heap_base = val & (PSPACE - 1);
        else
            heap_npg = val & ((64'd1 << 28) - 1);
    endtask

    task automatic set_window(longint unsigned base, longint unsigned npg);
        write_reg(CFG_BASE, base);
        write_reg(CFG_PAGES, npg);
    endtask

    always @(negedge clk)
    begin
        grant_t g;
        if (rst_n && done)
        begin
            if (expected_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: page %0h status %0d", alloc_page, status);
            end
            else
            begin
                g = expected_grants.pop_front();
                if (alloc_page !== g.page || status !== g.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected page %0h status %0d, got page %0h status %0d",
                                 g.page, g.st, alloc_page, status);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= WD_LIMIT)
        begin
            $display("first_fit_extent_allocator_core test failed");
            $finish;
        end
    end

    task automatic test_before_init();
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd10, 39'd8192);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd4095, 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd4095, 39'd8192);
    endtask

    task automatic test_basic_ops();
        set_window(100, 64);
        send_item(ffea_pkg::OP_INIT, '0, '0);
        send_item(ffea_pkg::OP_ALLOC, '0, '0);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd1);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd12288);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd4097);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd4096 * 100);
        send_item(ffea_pkg::OP_ALLOC, '0, {LEN_W{1'b1}});
        send_item(ffea_pkg::OP_FREE, 27'd100, '0);
        send_item(ffea_pkg::OP_FREE, 27'd100, 39'd100);
        send_item(ffea_pkg::OP_FREE, 27'd99, 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd163, 39'd8192);
        send_item(ffea_pkg::OP_FREE, 27'd110, 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd101, 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd100, 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd104, 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd102, 39'd8192);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd4096 * 58);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd4096 * 6);
        send_item(ffea_pkg::OP_NONE, {PAGE_W{1'b1}}, {LEN_W{1'b1}});
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd4096);
        drain();
    endtask

    task automatic test_table_full();
        set_window(0, 40);
        send_item(ffea_pkg::OP_INIT, '0, '0);
        repeat (40) send_item(ffea_pkg::OP_ALLOC, '0, 39'd4096);
        for (int i = 0; i <= 34; i += 2)
            send_item(ffea_pkg::OP_FREE, PAGE_W'(i), 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd1, 39'd4096);
        send_item(ffea_pkg::OP_FREE, 27'd36, 39'd4096);
        drain();
    endtask

    task automatic test_window_extremes();
        set_window(PSPACE - 1, (64'd1 << 28) - 1);
        send_item(ffea_pkg::OP_INIT, '0, '0);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd2);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd2);
        send_item(ffea_pkg::OP_FREE, {PAGE_W{1'b1}}, 39'd4096);
        send_item(ffea_pkg::OP_FREE, {PAGE_W{1'b1}}, 39'd8192);
        set_window(0, 64'd1 << 27);
        send_item(ffea_pkg::OP_INIT, '0, '0);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'h7F_FFFF_F001);
        send_item(ffea_pkg::OP_ALLOC, '0, {LEN_W{1'b1}});
        send_item(ffea_pkg::OP_FREE, '0, 39'h7F_FFFF_F000);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'h7F_FFFF_F000);
        send_item(ffea_pkg::OP_FREE, '0, 39'h40_0000_0000);
        set_window(5, 1);
        send_item(ffea_pkg::OP_INIT, '0, '0);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd4096);
        send_item(ffea_pkg::OP_ALLOC, '0, 39'd1);
        drain();
    endtask

    task automatic random_item();
        int    pick;
        int    k;
        span_t sp;
        longint unsigned cut;
        longint unsigned w;
        pick = $urandom_range(99);
        if (pick < 45)
            send_item(ffea_pkg::OP_ALLOC, PAGE_W'($urandom),
                      39'($urandom_range(1, 6)) * 4096 - 39'($urandom_range(4095)));
        else if (pick < 82 && held_spans.size() != 0)
        begin
            k  = $urandom_range(held_spans.size() - 1);
            sp = held_spans[k];
            held_spans.delete(k);
            cut = $urandom_range(1, sp.npg);
            send_item(ffea_pkg::OP_FREE, sp.page[PAGE_W-1:0], 39'(cut << PAGE_SHIFT));
            if (expected_grants[$].st != ffea_pkg::ST_OK)
                held_spans.push_back(sp);
            else if (cut < sp.npg)
                held_spans.push_back('{sp.page + cut, sp.npg - cut});
        end
        else if (pick < 85)
            send_item(ffea_pkg::OP_INIT, PAGE_W'($urandom), LEN_W'({$urandom, $urandom}));
        else if (pick < 88)
            send_item(ffea_pkg::OP_NONE, PAGE_W'($urandom), LEN_W'({$urandom, $urandom}));
        else if (pick < 93)
        begin
            w = heap_base + $urandom_range(heap_npg + 2);
            send_item(ffea_pkg::OP_FREE, w[PAGE_W-1:0], 39'($urandom_range(0, 4)) * 4096
                      + ((pick == 90) ? 39'($urandom_range(1, 4095)) : 39'd0));
        end
        else
            send_item(ffea_pkg::opcode_t'(2'($urandom_range(3))), PAGE_W'($urandom),
                      LEN_W'({$urandom, $urandom}));
    endtask

    task automatic test_random(int items, int pct, longint unsigned base, longint unsigned npg);
        idle_pct = pct;
        set_window(base, npg);
        send_item(ffea_pkg::OP_INIT, '0, '0);
        for (int i = 0; i < items; i++)
        begin
            sender_gap();
            random_item();
            if (i == items / 2)
                drain();
        end
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = '0;
        start_page   = '0;
        length_bytes = '0;
        cfg_valid    = 1'b0;
        cfg_index    = 1'b0;
        cfg_data     = '0;
        mismatches   = 0;
        stall_cnt    = 0;
        idle_pct     = 0;
        ext_cnt      = 0;
        heap_base    = 0;
        heap_npg     = 4096;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_init();
        test_basic_ops();
        test_table_full();
        test_window_extremes();
        test_random(370, 15, 1000, 48);
        test_random(370, 52, 64'h7FF_FF00, 200);
        test_random(370, 0, 0, 24);

        drain();
        if (mismatches == 0 && expected_grants.size() == 0)
            $display("first_fit_extent_allocator_core test passed");
        else
            $display("first_fit_extent_allocator_core test failed");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/ffea_pkg.sv
rtl/ffea_front.sv
rtl/ffea_queue.sv
rtl/ffea_back.sv
rtl/first_fit_extent_allocator_core.sv
rtl/ffea_checker.sv
sim/tb.sv
